// ----- src/hgpi_pkg.sv -----
// ----------------------------------------------------------------------------
// hgpi_pkg
// Shared types and constants of the hexagonal pad index block.
// ----------------------------------------------------------------------------
`default_nettype none

package hgpi_pkg;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 23;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PITCH          = 3'd0,
    CFG_ROW_HEIGHT     = 3'd1,
    CFG_HEX_INNER_HALF = 3'd2,
    CFG_READOUT_HALF   = 3'd3,
    CFG_PADS_LONG      = 3'd4,
    CFG_PADS_SHORT     = 3'd5
  } hgpi_cfg_idx_e;

  localparam int CfgW = 16;   // pitch, row height, inner half, pad counts
  localparam int LimW = 23;   // readout half width

  localparam logic [CfgW-1:0] PitchRst     = 16'd1400;
  localparam logic [CfgW-1:0] RowHeightRst = 16'd1212;
  localparam logic [CfgW-1:0] InnerHalfRst = 16'd404;
  localparam logic [LimW-1:0] ReadoutRst   = 23'd1000000;
  localparam logic [CfgW-1:0] PadsLongRst  = 16'd715;
  localparam logic [CfgW-1:0] PadsShortRst = 16'd715;

  // Datapath widths; a hit inside the area has |x|, |y| below 2^23.
  localparam int MagW    = 23;  // coordinate magnitude
  localparam int RowNumW = 25;  // row division numerator 2|y| + h
  localparam int RowW    = 25;  // signed row, room for the neighbour step
  localparam int PadNumW = 26;  // signed pad and pad division numerator
  localparam int DyW     = 18;  // signed doubled row distance
  localparam int DistW   = 19;  // signed doubled distance to a neighbour
  localparam int AbsW    = 18;  // magnitude of a doubled distance
  localparam int ProdW   = 34;  // 16 x 18 product
  localparam int SumW    = 36;  // hexagon test sum
  localparam int PadNoW  = 32;  // linear pad number

endpackage

`default_nettype wire

// ----- src/hgpi_hit_if.sv -----
// ----------------------------------------------------------------------------
// hgpi_hit_if
// Valid/ready channel carrying one hit position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hgpi_hit_if #(
  parameter int COORD_BITS = 24
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hit_x;
  logic signed [COORD_BITS-1:0] hit_y;

  modport source (output valid, output hit_x, output hit_y, input ready);
  modport sink   (input valid, input hit_x, input hit_y, output ready);

endinterface

`default_nettype wire

// ----- src/hgpi_pad_if.sv -----
// ----------------------------------------------------------------------------
// hgpi_pad_if
// Valid/ready channel carrying one pad result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hgpi_pad_if
  import hgpi_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic signed [PadNoW-1:0] pad_number;
  logic                     outside_area;

  modport source (output valid, output pad_number, output outside_area, input ready);
  modport sink   (input valid, input pad_number, input outside_area, output ready);

endinterface

`default_nettype wire

// ----- src/hgpi_div_pipe.sv -----
// ----------------------------------------------------------------------------
// hgpi_div_pipe
// Pipelined restoring divider, one quotient bit per register stage, with a
// side payload that travels alongside the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpi_div_pipe #(
  parameter int NumW  = 25,
  parameter int DenW  = 17,
  parameter int SideW = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW-1:0]  vld_q;
  logic [DenW-1:0]  rem_q  [NumW];
  logic [NumW-1:0]  work_q [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_step
    logic             vld_in;
    logic [DenW-1:0]  rem_in;
    logic [NumW-1:0]  work_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    shf;
    logic [DenW:0]    dif;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign work_in = num_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign side_in = side_q[k-1];
    end

    // The partial remainder stays below the divisor, so one trial
    // subtraction decides each quotient bit.
    assign shf = {rem_in, work_in[NumW-1]};
    assign ge  = (shf >= {1'b0, den_i});
    assign dif = shf - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= ge ? dif[DenW-1:0] : shf[DenW-1:0];
        work_q[k] <= {work_in[NumW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NumW-1];
  assign quo_o  = work_q[NumW-1];
  assign rem_o  = rem_q[NumW-1];
  assign side_o = side_q[NumW-1];

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> (rem_o < den_i))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ----- src/hex_grid_pad_index.sv -----
// ----------------------------------------------------------------------------
// hex_grid_pad_index
// Maps a hit position to the linear number of the hexagonal pad it falls in.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents                 handshake
//  hit_i     in   hit_x, hit_y                  valid / ready
//  pad_o     out  pad_number, outside_area      valid / ready
//  cfg       in   cfg_idx_i, cfg_data_i         cfg_we_i, no back-pressure
//
//  One hit is taken every cycle while the output is not stalled; the two
//  pipelined dividers (25 and 26 stages) run in series with nine other stages.
//  Reset clears all valid bits and loads the register defaults; there is no
//  clearing pass. A stalled output freezes the whole pipeline, and a one-beat
//  skid buffer keeps the input ready registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_grid_pad_index
  import hgpi_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  hgpi_hit_if.sink            hit_i,
  hgpi_pad_if.source          pad_o
);

  localparam int CmpW   = (COORD_BITS > LimW) ? COORD_BITS : LimW;
  localparam int Side1W = 3 + MagW;
  localparam int Side2W = 3 + RowW + DyW;
  localparam int Den1W  = CfgW + 1;
  localparam int Den2W  = CfgW + 2;

  function automatic logic [AbsW-1:0] abs_dist(input logic [DistW-1:0] v);
    logic [DistW-1:0] n;
    n = -v;
    return v[DistW-1] ? n[AbsW-1:0] : v[AbsW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] pitch_q, row_height_q, inner_half_q, pads_long_q, pads_short_q;
  logic [LimW-1:0] readout_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q        <= PitchRst;
      row_height_q   <= RowHeightRst;
      inner_half_q   <= InnerHalfRst;
      readout_half_q <= ReadoutRst;
      pads_long_q    <= PadsLongRst;
      pads_short_q   <= PadsShortRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PITCH:          pitch_q        <= cfg_data_i[CfgW-1:0];
        CFG_ROW_HEIGHT:     row_height_q   <= cfg_data_i[CfgW-1:0];
        CFG_HEX_INNER_HALF: inner_half_q   <= cfg_data_i[CfgW-1:0];
        CFG_READOUT_HALF:   readout_half_q <= cfg_data_i[LimW-1:0];
        CFG_PADS_LONG:      pads_long_q    <= cfg_data_i[CfgW-1:0];
        CFG_PADS_SHORT:     pads_short_q   <= cfg_data_i[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // A zero pitch or row height is taken as one.
  logic [CfgW-1:0] p_eff, h_eff;
  assign p_eff = (pitch_q == '0) ? CfgW'(1) : pitch_q;
  assign h_eff = (row_height_q == '0) ? CfgW'(1) : row_height_q;

  // --------------------------------------------------------------------------
  // Flow control and input skid buffer
  // --------------------------------------------------------------------------
  logic adv, in_fire, out_vld_q;
  logic skid_vld_q;
  logic [COORD_BITS-1:0] skid_x_q, skid_y_q;

  assign adv         = !out_vld_q || pad_o.ready;
  assign hit_i.ready = !skid_vld_q;
  assign in_fire     = hit_i.valid && !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (adv) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire && !adv) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !adv) begin
      skid_x_q <= COORD_BITS'(hit_i.hit_x);
      skid_y_q <= COORD_BITS'(hit_i.hit_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: magnitudes and area check
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] src_x, src_y, ax_full, ay_full;
  logic [CmpW-1:0]       ax_c, ay_c, lim_c;
  logic                  a_vld_d;

  assign src_x   = skid_vld_q ? skid_x_q : COORD_BITS'(hit_i.hit_x);
  assign src_y   = skid_vld_q ? skid_y_q : COORD_BITS'(hit_i.hit_y);
  assign ax_full = src_x[COORD_BITS-1] ? -src_x : src_x;
  assign ay_full = src_y[COORD_BITS-1] ? -src_y : src_y;
  assign ax_c    = CmpW'(ax_full);
  assign ay_c    = CmpW'(ay_full);
  assign lim_c   = CmpW'(readout_half_q);
  assign a_vld_d = skid_vld_q || in_fire;

  logic            a_vld_q, a_out_q, a_sx_q, a_sy_q;
  logic [MagW-1:0] a_ax_q, a_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_out_q <= (ax_c > lim_c) || (ay_c > lim_c);
      a_sx_q  <= src_x[COORD_BITS-1];
      a_sy_q  <= src_y[COORD_BITS-1];
      a_ax_q  <= ax_c[MagW-1:0];
      a_ay_q  <= ay_c[MagW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Row division: round(|y| / h) as floor((2|y| + h) / 2h)
  // --------------------------------------------------------------------------
  logic [RowNumW-1:0] r_num, r_quo;
  logic [Den1W-1:0]   r_rem;
  logic [Side1W-1:0]  r_side;
  logic               r_vld;

  assign r_num = RowNumW'({a_ay_q, 1'b0}) + RowNumW'(h_eff);

  hgpi_div_pipe #(
    .NumW (RowNumW),
    .DenW (Den1W),
    .SideW(Side1W)
  ) u_row_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .vld_i (a_vld_q),
    .num_i (r_num),
    .den_i ({h_eff, 1'b0}),
    .side_i({a_out_q, a_sx_q, a_sy_q, a_ax_q}),
    .vld_o (r_vld),
    .quo_o (r_quo),
    .rem_o (r_rem),
    .side_o(r_side)
  );

  // --------------------------------------------------------------------------
  // Prep stage: signed row, row distance and pad numerator 2x + offset
  // --------------------------------------------------------------------------
  logic            r_out, r_sx, r_sy;
  logic [MagW-1:0] r_ax;
  logic [RowW-1:0] row_u, row_c, x_u, x_c;
  logic [DyW-1:0]  dy_m, dy_c;
  logic [PadNumW-1:0] n_c;

  assign {r_out, r_sx, r_sy, r_ax} = r_side;
  assign row_u = RowW'(r_quo[MagW-1:0]);
  assign row_c = r_sy ? -row_u : row_u;
  // Remainder minus h is the doubled distance to the row centre.
  assign dy_m  = DyW'(r_rem) - DyW'(h_eff);
  assign dy_c  = r_sy ? -dy_m : dy_m;
  assign x_u   = RowW'(r_ax);
  assign x_c   = r_sx ? -x_u : x_u;
  assign n_c   = {x_c, 1'b0} + (r_quo[0] ? PadNumW'(p_eff) : '0);

  logic               pr_vld_q, pr_out_q, pr_odd_q;
  logic [RowW-1:0]    pr_row_q;
  logic [DyW-1:0]     pr_dy_q;
  logic [PadNumW-1:0] pr_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (adv) begin
      pr_vld_q <= r_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_out_q <= r_out;
      pr_odd_q <= r_quo[0];
      pr_row_q <= row_c;
      pr_dy_q  <= dy_c;
      pr_n_q   <= n_c;
    end
  end

  // --------------------------------------------------------------------------
  // Pad division: round(|n| / 2p) as floor((2|n| + 2p) / 4p)
  // --------------------------------------------------------------------------
  logic               sn;
  logic [PadNumW-1:0] an, p_num, p_quo;
  logic [Den2W-1:0]   p_rem;
  logic [Side2W-1:0]  p_side;
  logic               p_vld;

  assign sn    = pr_n_q[PadNumW-1];
  assign an    = sn ? -pr_n_q : pr_n_q;
  assign p_num = {an[PadNumW-2:0], 1'b0} + PadNumW'({p_eff, 1'b0});

  hgpi_div_pipe #(
    .NumW (PadNumW),
    .DenW (Den2W),
    .SideW(Side2W)
  ) u_pad_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .vld_i (pr_vld_q),
    .num_i (p_num),
    .den_i ({p_eff, 2'b00}),
    .side_i({pr_out_q, sn, pr_odd_q, pr_row_q, pr_dy_q}),
    .vld_o (p_vld),
    .quo_o (p_quo),
    .rem_o (p_rem),
    .side_o(p_side)
  );

  // --------------------------------------------------------------------------
  // Distance stage: signed pad and doubled x distance to its centre
  // --------------------------------------------------------------------------
  logic            p_out, p_sn, p_odd;
  logic [RowW-1:0] p_row;
  logic [DyW-1:0]  p_dy, dx_m, dx_c;
  logic [PadNumW-1:0] pad_c;

  assign {p_out, p_sn, p_odd, p_row, p_dy} = p_side;
  assign pad_c = p_sn ? -p_quo : p_quo;
  // The remainder is even; half of it minus p is the doubled x distance.
  assign dx_m  = DyW'(p_rem[Den2W-1:1]) - DyW'(p_eff);
  assign dx_c  = p_sn ? -dx_m : dx_m;

  logic               ds_vld_q, ds_out_q, ds_odd_q;
  logic [RowW-1:0]    ds_row_q;
  logic [PadNumW-1:0] ds_pad_q;
  logic [DyW-1:0]     ds_dx_q, ds_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_vld_q <= 1'b0;
    end else if (adv) begin
      ds_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_out_q <= p_out;
      ds_odd_q <= p_odd;
      ds_row_q <= p_row;
      ds_pad_q <= pad_c;
      ds_dx_q  <= dx_c;
      ds_dy_q  <= p_dy;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude stage: distances to the hexagon and its neighbours
  // Index 0 is the estimate, 1 and 2 the x shifts +p and -p, and for y the
  // shifts -2h (row above) and +2h (row below).
  // --------------------------------------------------------------------------
  logic [DistW-1:0] dx_e, dy_e, p_e, h2_e;

  assign dx_e = DistW'(signed'(ds_dx_q));
  assign dy_e = DistW'(signed'(ds_dy_q));
  assign p_e  = DistW'(p_eff);
  assign h2_e = DistW'({h_eff, 1'b0});

  logic               ab_vld_q, ab_out_q, ab_odd_q;
  logic [RowW-1:0]    ab_row_q;
  logic [PadNumW-1:0] ab_pad_q;
  logic [AbsW-1:0]    ab_adx_q [3];
  logic [AbsW-1:0]    ab_ady_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_vld_q <= 1'b0;
    end else if (adv) begin
      ab_vld_q <= ds_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ab_out_q    <= ds_out_q;
      ab_odd_q    <= ds_odd_q;
      ab_row_q    <= ds_row_q;
      ab_pad_q    <= ds_pad_q;
      ab_adx_q[0] <= abs_dist(dx_e);
      ab_adx_q[1] <= abs_dist(dx_e + p_e);
      ab_adx_q[2] <= abs_dist(dx_e - p_e);
      ab_ady_q[0] <= abs_dist(dy_e);
      ab_ady_q[1] <= abs_dist(dy_e - h2_e);
      ab_ady_q[2] <= abs_dist(dy_e + h2_e);
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage
  // --------------------------------------------------------------------------
  logic               mu_vld_q, mu_out_q, mu_odd_q;
  logic [RowW-1:0]    mu_row_q;
  logic [PadNumW-1:0] mu_pad_q;
  logic [2*CfgW-1:0]  mu_pq_q;
  logic [ProdW-1:0]   mu_qdx_q [3];
  logic [ProdW-1:0]   mu_pdy_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (adv) begin
      mu_vld_q <= ab_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_out_q <= ab_out_q;
      mu_odd_q <= ab_odd_q;
      mu_row_q <= ab_row_q;
      mu_pad_q <= ab_pad_q;
      mu_pq_q  <= p_eff * inner_half_q;
      for (int i = 0; i < 3; i++) begin
        mu_qdx_q[i] <= ProdW'(inner_half_q) * ProdW'(ab_adx_q[i]);
        mu_pdy_q[i] <= ProdW'(p_eff) * ProdW'(ab_ady_q[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hexagon tests: 4pq >= 2q|dx| + p|dy|
  // --------------------------------------------------------------------------
  logic [SumW-1:0] lhs;
  logic [3:0]      hit_t;

  assign lhs = SumW'({mu_pq_q, 2'b00});
  assign hit_t[0] = lhs >= (SumW'({mu_qdx_q[0], 1'b0}) + SumW'(mu_pdy_q[0]));
  assign hit_t[1] = lhs >= (SumW'({mu_qdx_q[1], 1'b0}) + SumW'(mu_pdy_q[1]));
  assign hit_t[2] = lhs >= (SumW'({mu_qdx_q[2], 1'b0}) + SumW'(mu_pdy_q[1]));
  assign hit_t[3] = lhs >= (SumW'({mu_qdx_q[1], 1'b0}) + SumW'(mu_pdy_q[2]));

  logic               cm_vld_q, cm_out_q, cm_odd_q;
  logic [RowW-1:0]    cm_row_q;
  logic [PadNumW-1:0] cm_pad_q;
  logic [3:0]         cm_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_vld_q <= 1'b0;
    end else if (adv) begin
      cm_vld_q <= mu_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cm_out_q <= mu_out_q;
      cm_odd_q <= mu_odd_q;
      cm_row_q <= mu_row_q;
      cm_pad_q <= mu_pad_q;
      cm_hit_q <= hit_t;
    end
  end

  // --------------------------------------------------------------------------
  // Selection stage: first hexagon that holds the hit, right-down otherwise
  // --------------------------------------------------------------------------
  logic [RowW-1:0]    se_row_d;
  logic [PadNumW-1:0] se_pad_d, pad_inc, pad_dec;

  // A step to the next row flips the parity, so the shift is the old even bit.
  assign pad_inc = cm_pad_q + PadNumW'(!cm_odd_q);
  assign pad_dec = pad_inc - PadNumW'(1);

  always_comb begin
    priority if (cm_hit_q[0]) begin
      se_row_d = cm_row_q;
      se_pad_d = cm_pad_q;
    end else if (cm_hit_q[1]) begin
      se_row_d = cm_row_q + RowW'(1);
      se_pad_d = pad_dec;
    end else if (cm_hit_q[2]) begin
      se_row_d = cm_row_q + RowW'(1);
      se_pad_d = pad_inc;
    end else if (cm_hit_q[3]) begin
      se_row_d = cm_row_q - RowW'(1);
      se_pad_d = pad_dec;
    end else begin
      se_row_d = cm_row_q - RowW'(1);
      se_pad_d = pad_inc;
    end
  end

  logic               se_vld_q, se_out_q;
  logic [RowW-1:0]    se_row_q;
  logic [PadNumW-1:0] se_pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_vld_q <= 1'b0;
    end else if (adv) begin
      se_vld_q <= cm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      se_out_q <= cm_out_q;
      se_row_q <= se_row_d;
      se_pad_q <= se_pad_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pad number: floor(row/2) * (long + short) plus the pad, plus long for an odd row
  // --------------------------------------------------------------------------
  logic [PadNoW-1:0] half_e, pair_e, pad_e;

  assign half_e = {{(PadNoW-RowW+1){se_row_q[RowW-1]}}, se_row_q[RowW-1:1]};
  assign pair_e = PadNoW'(pads_long_q) + PadNoW'(pads_short_q);
  assign pad_e  = {{(PadNoW-PadNumW){se_pad_q[PadNumW-1]}}, se_pad_q};

  logic              im_vld_q, im_out_q;
  logic [PadNoW-1:0] im_prod_q, im_add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      im_vld_q <= 1'b0;
    end else if (adv) begin
      im_vld_q <= se_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      im_out_q  <= se_out_q;
      im_prod_q <= half_e * pair_e;
      im_add_q  <= pad_e + (se_row_q[0] ? PadNoW'(pads_long_q) : '0);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [PadNoW-1:0] out_pad_q;
  logic              out_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= im_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pad_q  <= im_out_q ? '0 : (im_prod_q + im_add_q);
      out_flag_q <= im_out_q;
    end
  end

  assign pad_o.valid        = out_vld_q;
  assign pad_o.pad_number   = out_pad_q;
  assign pad_o.outside_area = out_flag_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid buffer holds a beat without a stalled output");

  a_dx_within_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ab_vld_q && !ab_out_q) |-> (ab_adx_q[0] <= AbsW'(p_eff)))
    else $error("x distance to the estimated pad exceeds the pitch");

  a_dy_within_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ab_vld_q && !ab_out_q) |-> (ab_ady_q[0] <= AbsW'(h_eff)))
    else $error("y distance to the estimated row exceeds the row height");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_o.valid && pad_o.outside_area) |-> (pad_o.pad_number == '0))
    else $error("outside hit carries a non-zero pad number");

endmodule

`default_nettype wire
